>>> rtl/tgfw_pkg.sv
// Shared types, constants and font functions for the text glyph framebuffer writer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tgfw_pkg;

   localparam int DISPLAY_WIDTH = 128;
   localparam int PAGE_COUNT    = 8;
   localparam int MAX_DIGITS    = 10;
   localparam int STORE_SIZE    = PAGE_COUNT * DISPLAY_WIDTH;
   localparam int ADDR_W        = $clog2(STORE_SIZE);
   localparam int POS_W         = $clog2(MAX_DIGITS);

   localparam logic [2:0] REQ_CURSOR = 3'd0;
   localparam logic [2:0] REQ_CHAR   = 3'd1;
   localparam logic [2:0] REQ_LARGE  = 3'd2;
   localparam logic [2:0] REQ_NUM    = 3'd3;
   localparam logic [2:0] REQ_LNUM   = 3'd4;
   localparam logic [2:0] REQ_CLEAR  = 3'd5;
   localparam logic [2:0] REQ_READ   = 3'd6;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  char_code;
      logic [3:0]  page_sel;
      logic [7:0]  column_sel;
      logic [31:0] number_value;
   } tgfw_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] cursor_page;
      logic [7:0] cursor_column;
   } tgfw_rsp_type;

   typedef enum logic [2:0] {
      OP_NOP, OP_CURSOR, OP_CHAR, OP_LARGE, OP_NUM, OP_LNUM, OP_CLEAR, OP_READ
   } tgfw_op_type;

   typedef struct packed {
      tgfw_op_type op;
      logic [7:0]  code;
      logic [2:0]  page;
      logic [7:0]  column;
      logic [31:0] value;
   } tgfw_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIGIT, ST_PLACE, ST_DRAW, ST_READ, ST_FINISH
   } tgfw_state_type;

   typedef logic [4:0][7:0] tgfw_glyph_type;

   function automatic tgfw_glyph_type font_cols(input logic [7:0] code);
      tgfw_glyph_type f;
      unique case (code)
         8'h30: f = {8'h3e, 8'h45, 8'h49, 8'h51, 8'h3e};
         8'h31: f = {8'h00, 8'h40, 8'h7f, 8'h42, 8'h00};
         8'h32: f = {8'h46, 8'h49, 8'h49, 8'h51, 8'h62};
         8'h33: f = {8'h36, 8'h49, 8'h49, 8'h49, 8'h22};
         8'h34: f = {8'h10, 8'h7f, 8'h12, 8'h14, 8'h18};
         8'h35: f = {8'h31, 8'h49, 8'h49, 8'h49, 8'h2f};
         8'h36: f = {8'h32, 8'h49, 8'h49, 8'h49, 8'h3e};
         8'h37: f = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         8'h38: f = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: f = {8'h3e, 8'h49, 8'h49, 8'h49, 8'h26};
         8'h54: f = {8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
         8'h41: f = {8'h7e, 8'h09, 8'h09, 8'h09, 8'h7e};
         8'h53: f = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
         8'h4b: f = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7f};
         8'h45: f = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7f};
         8'h49: f = {8'h41, 8'h41, 8'h7f, 8'h41, 8'h41};
         8'h4d: f = {8'h7f, 8'h02, 8'h04, 8'h02, 8'h7f};
         8'h52: f = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7f};
         8'h3a: f = {8'h00, 8'h36, 8'h00, 8'h36, 8'h00};
         8'h2e: f = {8'h00, 8'h00, 8'h60, 8'h00, 8'h00};
         8'h2b: f = {8'h08, 8'h08, 8'h3e, 8'h08, 8'h08};
         8'h20: f = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         default: f = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      endcase
      return f;
   endfunction

   function automatic logic [31:0] pow10(input logic [POS_W-1:0] pos);
      logic [31:0] p;
      unique case (pos)
         4'd0: p = 32'd1;
         4'd1: p = 32'd10;
         4'd2: p = 32'd100;
         4'd3: p = 32'd1000;
         4'd4: p = 32'd10000;
         4'd5: p = 32'd100000;
         4'd6: p = 32'd1000000;
         4'd7: p = 32'd10000000;
         4'd8: p = 32'd100000000;
         4'd9: p = 32'd1000000000;
         default: p = 32'd1;
      endcase
      return p;
   endfunction

   function automatic logic [15:0] widen(input logic [7:0] b);
      logic [15:0] w;
      for (int i = 0; i < 8; i++) begin
         w[2*i +: 2] = {2{b[i]}};
      end
      return w;
   endfunction

endpackage

>>> rtl/tgfw_front.sv
// Front end: accepts request items and decodes them into back-end commands.
// Depends on tgfw_pkg.
`timescale 1ns / 1ps

module tgfw_front (
   input  logic                  enable,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tgfw_pkg::tgfw_req_type req_data,
   input  logic                  push_ready,
   output logic                  push,
   output tgfw_pkg::tgfw_cmd_type push_cmd
);
   import tgfw_pkg::*;

   logic in_range;

   assign req_ready = enable && push_ready;
   assign push      = req_valid && req_ready;
   assign in_range  = (req_data.page_sel < 4'(PAGE_COUNT)) &&
                      ({1'b0, req_data.column_sel} < 9'(DISPLAY_WIDTH));

   always_comb begin
      push_cmd.code   = req_data.char_code;
      push_cmd.page   = req_data.page_sel[2:0];
      push_cmd.column = req_data.column_sel;
      push_cmd.value  = req_data.number_value;
      unique case (req_data.req_type)
         REQ_CURSOR: push_cmd.op = in_range ? OP_CURSOR : OP_NOP;
         REQ_CHAR:   push_cmd.op = OP_CHAR;
         REQ_LARGE:  push_cmd.op = OP_LARGE;
         REQ_NUM:    push_cmd.op = OP_NUM;
         REQ_LNUM:   push_cmd.op = OP_LNUM;
         REQ_CLEAR:  push_cmd.op = OP_CLEAR;
         REQ_READ:   push_cmd.op = in_range ? OP_READ : OP_NOP;
         default:    push_cmd.op = OP_NOP;
      endcase
   end

endmodule

>>> rtl/tgfw_queue.sv
// Two-entry command queue between front and back end.
// Depends on tgfw_pkg.
`timescale 1ns / 1ps

module tgfw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  push_ready,
   input  tgfw_pkg::tgfw_cmd_type push_cmd,
   input  logic                  pop,
   output logic                  head_valid,
   output tgfw_pkg::tgfw_cmd_type head_cmd
);
   import tgfw_pkg::*;

   tgfw_cmd_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/tgfw_back.sv
// Back end: sequencer that owns the framebuffer memory, the cursor, the
// decimal digit unit and the result register. Depends on tgfw_pkg.
`timescale 1ns / 1ps

module tgfw_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  tgfw_pkg::tgfw_cmd_type cmd,
   output logic                  pop,
   output logic                  init_done,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tgfw_pkg::tgfw_rsp_type rsp_data
);
   import tgfw_pkg::*;

   logic [7:0] mem [STORE_SIZE];

   tgfw_state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic       clr_resp_ff, clr_resp_in;
   logic       init_ff, init_in;
   logic [2:0] page_ff, page_in;
   logic [7:0] col_ff, col_in;
   logic       rsp_valid_ff, rsp_valid_in;
   tgfw_rsp_type rsp_ff, rsp_in;
   tgfw_glyph_type glyph_ff, glyph_in;
   logic       large_ff, large_in;
   logic       num_ff, num_in;
   logic       is_read_ff, is_read_in;
   logic [4:0] step_ff, step_in;
   logic [31:0] val_ff, val_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       started_ff, started_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [7:0] rd_q_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic [31:0]       pow;
   logic [2:0]        gx;
   logic [7:0]        gbyte;
   logic [15:0]       gwide;
   logic [2:0]        wpage;
   logic [7:0]        wcol;
   logic              last_step;
   logic [2:0]        p1;
   logic [3:0]        p2;

   assign init_done = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pow       = pow10(pos_ff);

   always_comb begin
      gx        = large_ff ? step_ff[4:2] : step_ff[2:0];
      gbyte     = (gx < 3'd5) ? glyph_ff[gx] : 8'h00;
      gwide     = widen(gbyte);
      last_step = large_ff ? (step_ff == 5'd23) : (step_ff == 5'd5);
      if (large_ff) begin
         wpage = page_ff + 3'(step_ff[1]);
         wcol  = col_ff + {4'd0, step_ff[4:2], 1'b0} + 8'(step_ff[0]);
      end else begin
         wpage = page_ff;
         wcol  = col_ff + {5'd0, step_ff[2:0]};
      end
      p1 = (page_ff > 3'(PAGE_COUNT - 2)) ? 3'(PAGE_COUNT - 2) : page_ff;
      p2 = {1'b0, p1} + 4'd2;
      if (p2 >= 4'(PAGE_COUNT)) begin
         p2 = p2 - 4'(PAGE_COUNT);
      end
      if (p2 > 4'(PAGE_COUNT - 2)) begin
         p2 = 4'(PAGE_COUNT - 2);
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      clr_resp_in  = clr_resp_ff;
      init_in      = init_ff;
      page_in      = page_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      glyph_in     = glyph_ff;
      large_in     = large_ff;
      num_in       = num_ff;
      is_read_in   = is_read_ff;
      step_in      = step_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      started_in   = started_ff;
      rd_addr_in   = rd_addr_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = 8'h00;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(STORE_SIZE - 1)) begin
               init_in  = 1'b1;
               state_in = clr_resp_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               pop        = 1'b1;
               is_read_in = 1'b0;
               large_in   = (cmd.op == OP_LARGE) || (cmd.op == OP_LNUM);
               num_in     = 1'b0;
               unique case (cmd.op)
                  OP_NOP: state_in = ST_FINISH;
                  OP_CURSOR: begin
                     page_in  = cmd.page;
                     col_in   = cmd.column;
                     state_in = ST_FINISH;
                  end
                  OP_READ: begin
                     is_read_in = 1'b1;
                     rd_addr_in = ADDR_W'(cmd.page) * ADDR_W'(DISPLAY_WIDTH) +
                                  ADDR_W'(cmd.column);
                     state_in   = ST_READ;
                  end
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     clr_resp_in = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  OP_CHAR, OP_LARGE: begin
                     glyph_in = font_cols(cmd.code);
                     state_in = ST_PLACE;
                  end
                  OP_NUM, OP_LNUM: begin
                     num_in     = 1'b1;
                     val_in     = cmd.value;
                     pos_in     = POS_W'(MAX_DIGITS - 1);
                     cnt_in     = 4'd0;
                     started_in = 1'b0;
                     state_in   = ST_DIGIT;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_DIGIT: begin
            if (val_ff >= pow) begin
               val_in = val_ff - pow;
               cnt_in = cnt_ff + 4'd1;
            end else if (cnt_ff != 4'd0 || started_ff || pos_ff == '0) begin
               glyph_in   = font_cols(8'h30 + {4'd0, cnt_ff});
               started_in = 1'b1;
               state_in   = ST_PLACE;
            end else begin
               pos_in = pos_ff - POS_W'(1);
            end
         end
         ST_PLACE: begin
            step_in  = 5'd0;
            state_in = ST_DRAW;
            if (large_ff) begin
               if (col_ff > 8'(DISPLAY_WIDTH - 12)) begin
                  col_in  = 8'd0;
                  page_in = p2[2:0];
               end else begin
                  page_in = p1;
               end
            end else if (col_ff > 8'(DISPLAY_WIDTH - 6)) begin
               col_in  = 8'd0;
               page_in = (page_ff == 3'(PAGE_COUNT - 1)) ? 3'd0 : page_ff + 3'd1;
            end
         end
         ST_DRAW: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(wpage) * ADDR_W'(DISPLAY_WIDTH) + ADDR_W'(wcol);
            mem_wdata = large_ff ? (step_ff[1] ? gwide[15:8] : gwide[7:0]) : gbyte;
            step_in   = step_ff + 5'd1;
            if (last_step) begin
               col_in = col_ff + (large_ff ? 8'd12 : 8'd6);
               if (num_ff && pos_ff != '0) begin
                  pos_in   = pos_ff - POS_W'(1);
                  cnt_in   = 4'd0;
                  state_in = ST_DIGIT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_in) begin
               rsp_valid_in         = 1'b1;
               rsp_in.read_data     = is_read_ff ? rd_q_ff : 8'h00;
               rsp_in.cursor_page   = page_ff;
               rsp_in.cursor_column = col_ff;
               clr_resp_in          = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_resp_ff  <= 1'b0;
         init_ff      <= 1'b0;
         page_ff      <= 3'd0;
         col_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_resp_ff  <= clr_resp_in;
         init_ff      <= init_in;
         page_ff      <= page_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      glyph_ff   <= glyph_in;
      large_ff   <= large_in;
      num_ff     <= num_in;
      is_read_ff <= is_read_in;
      step_ff    <= step_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      started_ff <= started_in;
      rd_addr_ff <= rd_addr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[rd_addr_ff];
   end

endmodule

>>> rtl/text_glyph_framebuffer_writer.sv
// The back-end sequencer writes one framebuffer byte per cycle and
// runs one item at a time; a two-entry queue lets the front accept meanwhile.
// Reset: synchronous; a clearing pass zeroes the store, req_ready low.
`timescale 1ns / 1ps

module text_glyph_framebuffer_writer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tgfw_pkg::tgfw_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tgfw_pkg::tgfw_rsp_type rsp_data
);
   import tgfw_pkg::*;

   logic         init_done;
   logic         push, push_ready, pop, head_valid;
   tgfw_cmd_type push_cmd, head_cmd;

   tgfw_front u_front (
      .enable     (init_done),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_ready (push_ready),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tgfw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tgfw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .pop       (pop),
      .init_done (init_done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/tgfw_checker.sv
// Port-level checker for the text glyph framebuffer writer, bound to the top level.
// Depends on tgfw_pkg.
`timescale 1ns / 1ps

module tgfw_port_props (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input tgfw_pkg::tgfw_req_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input tgfw_pkg::tgfw_rsp_type rsp_data
);
   import tgfw_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item dropped or changed while stalled");

   a_init_block: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("item taken or shown during clearing pass");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cursor_column <= 8'(DISPLAY_WIDTH))
      else $error("cursor column beyond display width");

   a_page_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.cursor_page <= 3'(PAGE_COUNT - 1))
      else $error("cursor page beyond page count");

endmodule

bind text_glyph_framebuffer_writer tgfw_port_props u_tgfw_port_props (.*);

>>> tb/tgfw_checker.sv
// Checker for the text glyph framebuffer writer: watches both channels, predicts
// each result from its own framebuffer model and compares field by field.
// Depends on tgfw_pkg for the request and result types.
`timescale 1ns / 1ps

module tgfw_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  tgfw_pkg::tgfw_req_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tgfw_pkg::tgfw_rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending_count
);
   import tgfw_pkg::*;

   logic [7:0] screen [STORE_SIZE];
   int unsigned pen_page;
   int unsigned pen_col;
   tgfw_rsp_type expected_rsps [$];

   function automatic logic [39:0] glyph_of(input logic [7:0] code);
      case (code)
         "0": return 40'h3e_51_49_45_3e;
         "1": return 40'h00_42_7f_40_00;
         "2": return 40'h62_51_49_49_46;
         "3": return 40'h22_49_49_49_36;
         "4": return 40'h18_14_12_7f_10;
         "5": return 40'h2f_49_49_49_31;
         "6": return 40'h3e_49_49_49_32;
         "7": return 40'h01_71_09_05_03;
         "8": return 40'h36_49_49_49_36;
         "9": return 40'h26_49_49_49_3e;
         "T": return 40'h01_01_7f_01_01;
         "A": return 40'h7e_09_09_09_7e;
         "S": return 40'h46_49_49_49_31;
         "K": return 40'h7f_08_14_22_41;
         "E": return 40'h7f_49_49_49_41;
         "I": return 40'h41_41_7f_41_41;
         "M": return 40'h7f_02_04_02_7f;
         "R": return 40'h7f_09_19_29_46;
         ":": return 40'h00_36_00_36_00;
         ".": return 40'h00_00_60_00_00;
         "+": return 40'h08_08_3e_08_08;
         " ": return 40'h00_00_00_00_00;
         default: return 40'h08_08_08_08_08;
      endcase
   endfunction

   function automatic logic [7:0] glyph_col(input logic [7:0] code, input int x);
      logic [39:0] g;
      g = glyph_of(code);
      return (x < 5) ? g[39 - 8 * x -: 8] : 8'h00;
   endfunction

   function automatic void put_byte(input int unsigned pg, input int unsigned col,
                                    input logic [7:0] v);
      int unsigned a;
      a = pg * DISPLAY_WIDTH + col;
      if (a < STORE_SIZE) screen[a] = v;
   endfunction

   function automatic void draw_small(input logic [7:0] code);
      if (pen_col > DISPLAY_WIDTH - 6) begin
         pen_col = 0;
         pen_page = (pen_page + 1) % PAGE_COUNT;
      end
      for (int i = 0; i < 6; i++) put_byte(pen_page, pen_col + i, glyph_col(code, i));
      pen_col += 6;
   endfunction

   function automatic void draw_big(input logic [7:0] code);
      logic [7:0] src;
      logic [15:0] w;
      if (pen_page > PAGE_COUNT - 2) pen_page = PAGE_COUNT - 2;
      if (pen_col > DISPLAY_WIDTH - 12) begin
         pen_col = 0;
         pen_page = (pen_page + 2) % PAGE_COUNT;
      end
      if (pen_page > PAGE_COUNT - 2) pen_page = PAGE_COUNT - 2;
      for (int x = 0; x < 6; x++) begin
         src = glyph_col(code, x);
         for (int y = 0; y < 8; y++) w[2 * y +: 2] = {2{src[y]}};
         put_byte(pen_page, pen_col + 2 * x, w[7:0]);
         put_byte(pen_page, pen_col + 2 * x + 1, w[7:0]);
         put_byte(pen_page + 1, pen_col + 2 * x, w[15:8]);
         put_byte(pen_page + 1, pen_col + 2 * x + 1, w[15:8]);
      end
      pen_col += 12;
   endfunction

   function automatic void draw_decimal(input logic [31:0] value, input bit big);
      logic [7:0] digs [MAX_DIGITS];
      int n;
      n = 0;
      do begin
         digs[n] = 8'h30 + 8'(value % 10);
         value = value / 10;
         n++;
      end while (value != 0 && n < MAX_DIGITS);
      while (n > 0) begin
         n--;
         if (big) draw_big(digs[n]);
         else draw_small(digs[n]);
      end
   endfunction

   function automatic tgfw_rsp_type render_request(input tgfw_req_type r);
      tgfw_rsp_type o;
      logic [7:0] rd;
      rd = 8'h00;
      case (r.req_type)
         REQ_CURSOR: if (r.page_sel < PAGE_COUNT && r.column_sel < DISPLAY_WIDTH) begin
            pen_page = r.page_sel;
            pen_col = r.column_sel;
         end
         REQ_CHAR:  draw_small(r.char_code);
         REQ_LARGE: draw_big(r.char_code);
         REQ_NUM:   draw_decimal(r.number_value, 1'b0);
         REQ_LNUM:  draw_decimal(r.number_value, 1'b1);
         REQ_CLEAR: foreach (screen[i]) screen[i] = 8'h00;
         REQ_READ:  if (r.page_sel < PAGE_COUNT && r.column_sel < DISPLAY_WIDTH)
            rd = screen[r.page_sel * DISPLAY_WIDTH + r.column_sel];
         default: ;
      endcase
      o.read_data = rd;
      o.cursor_page = 3'(pen_page);
      o.cursor_column = 8'(pen_col);
      return o;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      tgfw_rsp_type e;
      if (reset) begin
         foreach (screen[i]) screen[i] = 8'h00;
         pen_page = 0;
         pen_col = 0;
         fail_count = 0;
         expected_rsps.delete();
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(render_request(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected item %h", rsp_data);
            end else begin
               e = expected_rsps.pop_front();
               if (e.read_data !== rsp_data.read_data ||
                   e.cursor_page !== rsp_data.cursor_page ||
                   e.cursor_column !== rsp_data.cursor_column) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected rd %h pg %0d col %0d, got rd %h pg %0d col %0d",
                        e.read_data, e.cursor_page, e.cursor_column, rsp_data.read_data,
                        rsp_data.cursor_page, rsp_data.cursor_column);
               end
            end
         end
      end
   end
endmodule

>>> tb/tb.sv
// Top of the text glyph framebuffer writer testbench: clock, reset, stimulus and verdict.
// Depends on tgfw_pkg, the block and tgfw_checker.
`timescale 1ns / 1ps

module tb;
   import tgfw_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tgfw_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tgfw_rsp_type rsp_data;
   int fail_count;
   int pending_count;
   int cycle_count = 0;
   bit steady = 1'b0;

   text_glyph_framebuffer_writer dut (.*);
   tgfw_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10000000) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) rsp_ready <= steady || ($urandom_range(99) >= 29);

   function automatic logic [7:0] pick_code();
      logic [7:0] set [23];
      set = '{"0","1","2","3","4","5","6","7","8","9","T","A","S","K","E","I","M",
              "R",":",".","+","-"," "};
      return ($urandom_range(3) == 0) ? 8'($urandom) : set[$urandom_range(22)];
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom_range(9);
         1: return $urandom_range(99999);
         2: return 32'hffff_ffff - $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [2:0] kind, input int unsigned code,
                       input int unsigned pg, input int unsigned col, input int unsigned v);
      while (!steady && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind, 8'(code), 4'(pg), 8'(col), v};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random();
      int r;
      r = $urandom_range(99);
      if (r < 12) send(REQ_CURSOR, $urandom, $urandom, ($urandom_range(3) == 0) ?
                       8'($urandom) : 8'($urandom_range(127)), $urandom);
      else if (r < 40) send(REQ_CHAR, pick_code(), $urandom, $urandom, $urandom);
      else if (r < 58) send(REQ_LARGE, pick_code(), $urandom, $urandom, $urandom);
      else if (r < 66) send(REQ_NUM, $urandom, $urandom, $urandom, pick_value());
      else if (r < 72) send(REQ_LNUM, $urandom, $urandom, $urandom, pick_value());
      else if (r < 73) send(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else if (r < 97) send(REQ_READ, $urandom, ($urandom_range(7) == 0) ? 4'($urandom) :
                            4'($urandom_range(7)), ($urandom_range(7) == 0) ? 8'($urandom) :
                            8'($urandom_range(127)), $urandom);
      else send(3'd7, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send(REQ_CHAR, "A", 0, 0, 0);
      send(REQ_READ, 0, 0, 0, 0);
      send(REQ_CURSOR, 0, 7, 127, 0);
      send(REQ_CHAR, 8'hff, 0, 0, 0);
      send(REQ_CURSOR, 0, 8, 0, 0);
      send(REQ_CURSOR, 0, 0, 128, 0);
      send(REQ_CURSOR, 0, 15, 255, 0);
      send(REQ_CURSOR, 0, 7, 120, 0);
      send(REQ_LARGE, "K", 0, 0, 0);
      send(REQ_LARGE, "M", 0, 0, 0);
      send(REQ_READ, 0, 6, 12, 0);
      send(REQ_READ, 0, 7, 13, 0);
      send(REQ_NUM, 0, 0, 0, 0);
      send(REQ_NUM, 0, 0, 0, 32'hffff_ffff);
      send(REQ_LNUM, 0, 0, 0, 32'd1234567890);
      send(REQ_READ, 0, 15, 255, 0);
      send(3'd7, 8'hff, 15, 255, 32'hffff_ffff);
      send(REQ_CLEAR, 0, 0, 0, 0);
      send(REQ_READ, 0, 0, 1, 0);
      for (int i = 0; i < 1750; i++) begin
         steady = (i >= 600 && i < 800);
         send_random();
      end
      req_valid <= 1'b0;
      steady = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
